@@ sv/eiahf_pkg.sv @@
// ----------------------------------------------------------------------------
// eiahf_pkg
// shared types and constants for the ethernet ipv4/arp header filter
// ----------------------------------------------------------------------------
package eiahf_pkg;

  typedef logic [5:0]  pos_t;
  typedef logic [2:0]  kind_t;
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [31:0] cfg_data_t;

  // configuration register indexes
  localparam cfg_idx_t REG_IP_FILTER_ENABLE  = 2'd0;
  localparam cfg_idx_t REG_IP_FILTER_ADDRESS = 2'd1;
  localparam cfg_idx_t REG_FILTER_MODE       = 2'd2;
  localparam cfg_idx_t REG_FILTER_PROTOCOL   = 2'd3;

  // filter modes
  localparam logic [1:0] MODE_NONE       = 2'd0;
  localparam logic [1:0] MODE_IPV4       = 2'd1;
  localparam logic [1:0] MODE_ARP        = 2'd2;
  localparam logic [1:0] MODE_IPV4_PROTO = 2'd3;

  // result kinds
  localparam kind_t KIND_MAC       = 3'd0;
  localparam kind_t KIND_TCP       = 3'd1;
  localparam kind_t KIND_UDP       = 3'd2;
  localparam kind_t KIND_ICMP      = 3'd3;
  localparam kind_t KIND_IPV4      = 3'd4;
  localparam kind_t KIND_ARP       = 3'd5;
  localparam kind_t KIND_TRUNCATED = 3'd6;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // byte positions within the frame
  localparam pos_t POS_SRC_MAC    = 6'd6;
  localparam pos_t POS_ETHERTYPE  = 6'd12;
  localparam pos_t POS_PAYLOAD    = 6'd14;
  localparam pos_t POS_IP_PROTO   = 6'd23;
  localparam pos_t POS_IP_SRC     = 6'd26;
  localparam pos_t POS_IP_DST     = 6'd30;
  localparam pos_t POS_SRC_PORT   = 6'd34;
  localparam pos_t POS_DST_PORT   = 6'd36;
  localparam pos_t POS_PORTS_END  = 6'd38;
  localparam pos_t POS_ARP_FIELDS_END = 6'd22;
  localparam pos_t POS_ARP_SENDER = 6'd28;
  localparam pos_t POS_ARP_TARGET = 6'd38;
  localparam pos_t POS_ARP_END    = 6'd42;
  localparam pos_t POS_MAX        = 6'd63;

  // minimum frame lengths
  localparam pos_t LEN_ETH      = 6'd14;
  localparam pos_t LEN_IP_PROTO = 6'd24;
  localparam pos_t LEN_IP_ADDR  = 6'd34;
  localparam pos_t LEN_IP_PORTS = 6'd38;
  localparam pos_t LEN_ARP      = 6'd42;

endpackage

@@ sv/eiahf_if.sv @@
// ----------------------------------------------------------------------------
// eiahf channel interfaces
// valid/ready channels for frame bytes in and header results out
// ----------------------------------------------------------------------------
interface eiahf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface eiahf_out_if;
  logic                 valid;
  logic                 ready;
  logic                 pass;
  eiahf_pkg::kind_t     kind;
  logic [47:0]          dest_mac;
  logic [47:0]          source_mac;
  logic [31:0]          source_ip;
  logic [31:0]          dest_ip;
  logic [15:0]          source_port;
  logic [15:0]          dest_port;
  logic [15:0]          arp_hardware_type;
  logic [15:0]          arp_protocol_type;
  logic [15:0]          arp_address_lengths;
  logic [15:0]          arp_opcode;

  modport source (
    output valid, output pass, output kind, output dest_mac, output source_mac,
    output source_ip, output dest_ip, output source_port, output dest_port,
    output arp_hardware_type, output arp_protocol_type,
    output arp_address_lengths, output arp_opcode,
    input ready
  );
  modport sink (
    input valid, input pass, input kind, input dest_mac, input source_mac,
    input source_ip, input dest_ip, input source_port, input dest_port,
    input arp_hardware_type, input arp_protocol_type,
    input arp_address_lengths, input arp_opcode,
    output ready
  );
endinterface

@@ sv/ethernet_ipv4_arp_header_filter_unit.sv @@
// ----------------------------------------------------------------------------
// ethernet_ipv4_arp_header_filter_unit
// parses ethernet/ipv4/arp headers from a byte stream and flags each frame
// ----------------------------------------------------------------------------
// the result is registered: it shows on the output in the cycle after the last byte
// throughput: one byte per cycle, limited only by the single result register
// reset (rst_n, synchronous): frame captures, byte position, filter
// registers and output valid all go to zero
// ----------------------------------------------------------------------------
module ethernet_ipv4_arp_header_filter_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  eiahf_in_if.sink              in_chan,
  eiahf_out_if.source           out_chan,
  input  logic                  cfg_wr_en,
  input  eiahf_pkg::cfg_idx_t   cfg_index,
  input  eiahf_pkg::cfg_data_t  cfg_wr_data
);

  // filter registers
  logic        ip_filter_enable_r;
  logic [31:0] ip_filter_address_r;
  logic [1:0]  filter_mode_r;
  logic [7:0]  filter_protocol_r;

  // frame capture state
  eiahf_pkg::pos_t pos_r, pos_nxt, pos_inc;
  logic [47:0] dest_mac_r, dest_mac_nxt;
  logic [47:0] source_mac_r, source_mac_nxt;
  logic [15:0] ethertype_r, ethertype_nxt;
  logic [7:0]  ip_proto_r, ip_proto_nxt;
  logic [31:0] source_ip_r, source_ip_nxt;
  logic [31:0] dest_ip_r, dest_ip_nxt;
  logic [15:0] source_port_r, source_port_nxt;
  logic [15:0] dest_port_r, dest_port_nxt;
  logic [63:0] arp_fields_r, arp_fields_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              pass_r;
  eiahf_pkg::kind_t  kind_r;
  logic [47:0]       o_dest_mac_r, o_source_mac_r;
  logic [31:0]       o_source_ip_r, o_dest_ip_r;
  logic [15:0]       o_source_port_r, o_dest_port_r;
  logic [63:0]       o_arp_r;

  logic              in_acc;
  logic              frame_end;
  logic [7:0]        b;
  eiahf_pkg::kind_t  kind_c;
  logic              is_ip, is_arp, pass_c;
  logic              keep_mac, keep_ports;

  // an output register parts the two sides: a new byte is taken whenever the
  // result slot is free or being drained this cycle
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign frame_end     = in_acc && in_chan.last_byte;
  assign b             = in_chan.frame_byte;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_filter_enable_r  <= 1'b0;
      ip_filter_address_r <= '0;
      filter_mode_r       <= eiahf_pkg::MODE_NONE;
      filter_protocol_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        eiahf_pkg::REG_IP_FILTER_ENABLE:  ip_filter_enable_r  <= cfg_wr_data[0];
        eiahf_pkg::REG_IP_FILTER_ADDRESS: ip_filter_address_r <= cfg_wr_data;
        eiahf_pkg::REG_FILTER_MODE:       filter_mode_r       <= cfg_wr_data[1:0];
        eiahf_pkg::REG_FILTER_PROTOCOL:   filter_protocol_r   <= cfg_wr_data[7:0];
        default: ;
      endcase
    end
  end

  // byte capture: each field shifts in its bytes, first byte most significant
  assign pos_inc = (pos_r == eiahf_pkg::POS_MAX) ? pos_r : pos_r + 6'd1;

  always_comb begin
    dest_mac_nxt    = dest_mac_r;
    source_mac_nxt  = source_mac_r;
    ethertype_nxt   = ethertype_r;
    ip_proto_nxt    = ip_proto_r;
    source_ip_nxt   = source_ip_r;
    dest_ip_nxt     = dest_ip_r;
    source_port_nxt = source_port_r;
    dest_port_nxt   = dest_port_r;
    arp_fields_nxt  = arp_fields_r;
    pos_nxt         = pos_r;
    if (in_acc) begin
      pos_nxt = pos_inc;
      if (pos_r < eiahf_pkg::POS_SRC_MAC) begin
        dest_mac_nxt = {dest_mac_r[39:0], b};
      end else if (pos_r < eiahf_pkg::POS_ETHERTYPE) begin
        source_mac_nxt = {source_mac_r[39:0], b};
      end else if (pos_r < eiahf_pkg::POS_PAYLOAD) begin
        ethertype_nxt = {ethertype_r[7:0], b};
      end else if (ethertype_r == eiahf_pkg::ETHERTYPE_IPV4) begin
        if (pos_r == eiahf_pkg::POS_IP_PROTO) begin
          ip_proto_nxt = b;
        end else if (pos_r >= eiahf_pkg::POS_IP_SRC && pos_r < eiahf_pkg::POS_IP_DST) begin
          source_ip_nxt = {source_ip_r[23:0], b};
        end else if (pos_r >= eiahf_pkg::POS_IP_DST && pos_r < eiahf_pkg::POS_SRC_PORT) begin
          dest_ip_nxt = {dest_ip_r[23:0], b};
        end else if (pos_r >= eiahf_pkg::POS_SRC_PORT && pos_r < eiahf_pkg::POS_DST_PORT) begin
          source_port_nxt = {source_port_r[7:0], b};
        end else if (pos_r >= eiahf_pkg::POS_DST_PORT && pos_r < eiahf_pkg::POS_PORTS_END) begin
          dest_port_nxt = {dest_port_r[7:0], b};
        end
      end else if (ethertype_r == eiahf_pkg::ETHERTYPE_ARP) begin
        // hardware type, protocol type, both lengths and opcode
        if (pos_r < eiahf_pkg::POS_ARP_FIELDS_END) begin
          arp_fields_nxt = {arp_fields_r[55:0], b};
        end else if (pos_r >= eiahf_pkg::POS_ARP_SENDER &&
                     pos_r < eiahf_pkg::POS_ARP_SENDER + 6'd4) begin
          source_ip_nxt = {source_ip_r[23:0], b};
        end else if (pos_r >= eiahf_pkg::POS_ARP_TARGET &&
                     pos_r < eiahf_pkg::POS_ARP_END) begin
          dest_ip_nxt = {dest_ip_r[23:0], b};
        end
      end
    end
  end

  // classify the frame from the captures as they stand after the last byte
  always_comb begin
    if (pos_nxt < eiahf_pkg::LEN_ETH) begin
      kind_c = eiahf_pkg::KIND_TRUNCATED;
    end else if (ethertype_nxt == eiahf_pkg::ETHERTYPE_IPV4) begin
      if (pos_nxt < eiahf_pkg::LEN_IP_PROTO) begin
        kind_c = eiahf_pkg::KIND_TRUNCATED;
      end else if (ip_proto_nxt == eiahf_pkg::PROTO_TCP ||
                   ip_proto_nxt == eiahf_pkg::PROTO_UDP) begin
        if (pos_nxt < eiahf_pkg::LEN_IP_PORTS)
          kind_c = eiahf_pkg::KIND_TRUNCATED;
        else if (ip_proto_nxt == eiahf_pkg::PROTO_TCP)
          kind_c = eiahf_pkg::KIND_TCP;
        else
          kind_c = eiahf_pkg::KIND_UDP;
      end else if (pos_nxt < eiahf_pkg::LEN_IP_ADDR) begin
        kind_c = eiahf_pkg::KIND_TRUNCATED;
      end else if (ip_proto_nxt == eiahf_pkg::PROTO_ICMP) begin
        kind_c = eiahf_pkg::KIND_ICMP;
      end else begin
        kind_c = eiahf_pkg::KIND_IPV4;
      end
    end else if (ethertype_nxt == eiahf_pkg::ETHERTYPE_ARP) begin
      kind_c = (pos_nxt < eiahf_pkg::LEN_ARP) ? eiahf_pkg::KIND_TRUNCATED
                                               : eiahf_pkg::KIND_ARP;
    end else begin
      kind_c = eiahf_pkg::KIND_MAC;
    end
  end

  assign is_ip  = (kind_c == eiahf_pkg::KIND_TCP) || (kind_c == eiahf_pkg::KIND_UDP) ||
                  (kind_c == eiahf_pkg::KIND_ICMP) || (kind_c == eiahf_pkg::KIND_IPV4);
  assign is_arp = (kind_c == eiahf_pkg::KIND_ARP);

  // which parts of the result belong to the kind
  assign keep_mac   = (kind_c != eiahf_pkg::KIND_TRUNCATED);
  assign keep_ports = (kind_c == eiahf_pkg::KIND_TCP) || (kind_c == eiahf_pkg::KIND_UDP);

  // address filter touches only ip and arp frames; mode filter on top of it
  always_comb begin
    pass_c = 1'b1;
    if ((is_ip || is_arp) && ip_filter_enable_r &&
        source_ip_nxt != ip_filter_address_r && dest_ip_nxt != ip_filter_address_r)
      pass_c = 1'b0;
    case (filter_mode_r)
      eiahf_pkg::MODE_IPV4:       if (!is_ip) pass_c = 1'b0;
      eiahf_pkg::MODE_ARP:        if (!is_arp) pass_c = 1'b0;
      eiahf_pkg::MODE_IPV4_PROTO: if (!is_ip || ip_proto_nxt != filter_protocol_r) pass_c = 1'b0;
      default: ;
    endcase
    if (kind_c == eiahf_pkg::KIND_TRUNCATED)
      pass_c = 1'b0;
  end

  // frame state: cleared at reset and at the end of every frame
  always_ff @(posedge clk) begin
    if (!rst_n || frame_end) begin
      pos_r         <= '0;
      dest_mac_r    <= '0;
      source_mac_r  <= '0;
      ethertype_r   <= '0;
      ip_proto_r    <= '0;
      source_ip_r   <= '0;
      dest_ip_r     <= '0;
      source_port_r <= '0;
      dest_port_r   <= '0;
      arp_fields_r  <= '0;
    end else begin
      pos_r         <= pos_nxt;
      dest_mac_r    <= dest_mac_nxt;
      source_mac_r  <= source_mac_nxt;
      ethertype_r   <= ethertype_nxt;
      ip_proto_r    <= ip_proto_nxt;
      source_ip_r   <= source_ip_nxt;
      dest_ip_r     <= dest_ip_nxt;
      source_port_r <= source_port_nxt;
      dest_port_r   <= dest_port_nxt;
      arp_fields_r  <= arp_fields_nxt;
    end
  end

  // result register valid
  always_comb begin
    if (frame_end)
      out_valid_nxt = 1'b1;
    else if (out_chan.ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else
      out_valid_r <= out_valid_nxt;
  end

  // result payload: fields that do not belong to the kind read as zero,
  // a truncated frame carries only its kind
  always_ff @(posedge clk) begin
    if (frame_end) begin
      pass_r          <= pass_c;
      kind_r          <= kind_c;
      o_dest_mac_r    <= keep_mac ? dest_mac_nxt : '0;
      o_source_mac_r  <= keep_mac ? source_mac_nxt : '0;
      o_source_ip_r   <= (is_ip || is_arp) ? source_ip_nxt : '0;
      o_dest_ip_r     <= (is_ip || is_arp) ? dest_ip_nxt : '0;
      o_source_port_r <= keep_ports ? source_port_nxt : '0;
      o_dest_port_r   <= keep_ports ? dest_port_nxt : '0;
      o_arp_r         <= is_arp ? arp_fields_nxt : '0;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.pass                = pass_r;
  assign out_chan.kind                = kind_r;
  assign out_chan.dest_mac            = o_dest_mac_r;
  assign out_chan.source_mac          = o_source_mac_r;
  assign out_chan.source_ip           = o_source_ip_r;
  assign out_chan.dest_ip             = o_dest_ip_r;
  assign out_chan.source_port         = o_source_port_r;
  assign out_chan.dest_port           = o_dest_port_r;
  assign out_chan.arp_hardware_type   = o_arp_r[63:48];
  assign out_chan.arp_protocol_type   = o_arp_r[47:32];
  assign out_chan.arp_address_lengths = o_arp_r[31:16];
  assign out_chan.arp_opcode          = o_arp_r[15:0];

endmodule

@@ sim/ethernet_ipv4_arp_header_filter_unit_test.sv @@
// ----------------------------------------------------------------------------
// ethernet_ipv4_arp_header_filter_unit_test
// self-checking bench for the ethernet/ipv4/arp header filter: frames are
// fed byte by byte over the input channel, every header result is checked
// against an in-bench parser and filter model or a typed-in result, with random idling on both
// channels and filter settings changed between frames
// ----------------------------------------------------------------------------
module ethernet_ipv4_arp_header_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import eiahf_pkg::*;

  // where a directed or random frame plants the filter address
  localparam logic [1:0] SLOT_NONE   = 2'd0;
  localparam logic [1:0] SLOT_SOURCE = 2'd1;
  localparam logic [1:0] SLOT_DEST   = 2'd2;

  localparam int NUM_PLAN      = 26;
  localparam int RANDOM_BYTES  = 440;
  localparam int RANDOM_FRAMES = 12;
  localparam int MAX_FRAME     = 80;
  localparam int STALL_LIMIT   = 2000;

  // one header result as it leaves the block
  typedef struct packed {
    logic        pass;
    kind_t       kind;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] arp_hw_type;
    logic [15:0] arp_proto_type;
    logic [15:0] arp_addr_lens;
    logic [15:0] arp_opcode;
  } header_rec_t;

  // one frame of stimulus plus the filter setting it runs under
  typedef struct packed {
    logic [15:0] ethertype;
    logic [7:0]  ip_proto;
    logic [6:0]  length;
    logic [7:0]  fill;
    logic        random_fill;
    logic [1:0]  addr_slot;
    logic        flt_en;
    logic [31:0] flt_addr;
    logic [1:0]  flt_mode;
    logic [7:0]  flt_proto;
    logic        pinned;
    kind_t       pin_kind;
    logic        pin_pass;
  } frame_row_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_wr_en;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wr_data;

  eiahf_in_if  frame_in ();
  eiahf_out_if result_out ();

  ethernet_ipv4_arp_header_filter_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (frame_in),
    .out_chan    (result_out),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // sideband that travels with each item: a typed-in result for this frame
  logic        item_pinned;
  header_rec_t item_pin;

  // parser model state
  pos_t        hdr_pos;
  logic [47:0] cap_dest_mac;
  logic [47:0] cap_source_mac;
  logic [15:0] cap_ethertype;
  logic [7:0]  cap_proto;
  logic [31:0] cap_source_ip;
  logic [31:0] cap_dest_ip;
  logic [15:0] cap_source_port;
  logic [15:0] cap_dest_port;
  logic [63:0] cap_arp;

  // filter registers as the block should hold them
  logic        shadow_ip_en;
  logic [31:0] shadow_ip_addr;
  logic [1:0]  shadow_mode;
  logic [7:0]  shadow_proto;

  // filter setting last written by the sender
  logic        cur_en;
  logic [31:0] cur_addr;
  logic [1:0]  cur_mode;
  logic [7:0]  cur_proto;

  header_rec_t expected_headers [$];
  frame_row_t  plan [NUM_PLAN];

  int header_mismatches = 0;
  int stall_cycles      = 0;
  int results_checked   = 0;
  int results_shown     = 0;
  int bytes_sent        = 0;
  int frames_sent       = 0;
  int config_changes    = 0;
  int kinds_seen [8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic clear_capture();
    hdr_pos         = '0;
    cap_dest_mac    = '0;
    cap_source_mac  = '0;
    cap_ethertype   = '0;
    cap_proto       = '0;
    cap_source_ip   = '0;
    cap_dest_ip     = '0;
    cap_source_port = '0;
    cap_dest_port   = '0;
    cap_arp         = '0;
  endtask

  // parser and filter model: takes one accepted byte, returns a result on
  // the byte marked last
  task automatic parse_header_byte(input logic [7:0] b, input logic last,
                                   output bit emit, output header_rec_t rec);
    pos_t  here;
    pos_t  len;
    kind_t k;
    logic  ok;
    logic  ip_kind;
    here = hdr_pos;
    emit = 1'b0;
    rec  = '0;
    if (here < POS_SRC_MAC) begin
      cap_dest_mac = {cap_dest_mac[39:0], b};
    end else if (here < POS_ETHERTYPE) begin
      cap_source_mac = {cap_source_mac[39:0], b};
    end else if (here < POS_PAYLOAD) begin
      cap_ethertype = {cap_ethertype[7:0], b};
    end else if (cap_ethertype == ETHERTYPE_IPV4) begin
      // fixed 20-byte ipv4 header, ports right behind it
      if (here == POS_IP_PROTO) cap_proto = b;
      else if (here >= POS_IP_SRC && here < POS_IP_DST)
        cap_source_ip = {cap_source_ip[23:0], b};
      else if (here >= POS_IP_DST && here < POS_SRC_PORT)
        cap_dest_ip = {cap_dest_ip[23:0], b};
      else if (here >= POS_SRC_PORT && here < POS_DST_PORT)
        cap_source_port = {cap_source_port[7:0], b};
      else if (here >= POS_DST_PORT && here < POS_PORTS_END)
        cap_dest_port = {cap_dest_port[7:0], b};
    end else if (cap_ethertype == ETHERTYPE_ARP) begin
      if (here < POS_ARP_FIELDS_END) cap_arp = {cap_arp[55:0], b};
      else if (here >= POS_ARP_SENDER && here < POS_ARP_SENDER + 6'd4)
        cap_source_ip = {cap_source_ip[23:0], b};
      else if (here >= POS_ARP_TARGET && here < POS_ARP_END)
        cap_dest_ip = {cap_dest_ip[23:0], b};
    end
    if (here < POS_MAX) hdr_pos = here + 6'd1;

    if (last) begin
      len = hdr_pos;
      if (len < LEN_ETH) begin
        k = KIND_TRUNCATED;
      end else if (cap_ethertype == ETHERTYPE_IPV4) begin
        if (len < LEN_IP_PROTO) k = KIND_TRUNCATED;
        else if (cap_proto == PROTO_TCP || cap_proto == PROTO_UDP)
          k = (len < LEN_IP_PORTS) ? KIND_TRUNCATED :
              (cap_proto == PROTO_TCP) ? KIND_TCP : KIND_UDP;
        else if (len < LEN_IP_ADDR) k = KIND_TRUNCATED;
        else k = (cap_proto == PROTO_ICMP) ? KIND_ICMP : KIND_IPV4;
      end else if (cap_ethertype == ETHERTYPE_ARP) begin
        k = (len < LEN_ARP) ? KIND_TRUNCATED : KIND_ARP;
      end else begin
        k = KIND_MAC;
      end

      rec.kind = k;
      if (k != KIND_TRUNCATED) begin
        ip_kind = (k >= KIND_TCP && k <= KIND_IPV4);
        ok = 1'b1;
        // address filter leaves mac-only frames alone
        if ((ip_kind || k == KIND_ARP) && shadow_ip_en &&
            cap_source_ip != shadow_ip_addr && cap_dest_ip != shadow_ip_addr)
          ok = 1'b0;
        if (shadow_mode == MODE_IPV4 && !ip_kind) ok = 1'b0;
        else if (shadow_mode == MODE_ARP && k != KIND_ARP) ok = 1'b0;
        else if (shadow_mode == MODE_IPV4_PROTO &&
                 (!ip_kind || cap_proto != shadow_proto)) ok = 1'b0;
        rec.pass       = ok;
        rec.dest_mac   = cap_dest_mac;
        rec.source_mac = cap_source_mac;
        if (k != KIND_MAC) begin
          rec.source_ip = cap_source_ip;
          rec.dest_ip   = cap_dest_ip;
        end
        if (k == KIND_TCP || k == KIND_UDP) begin
          rec.source_port = cap_source_port;
          rec.dest_port   = cap_dest_port;
        end
        if (k == KIND_ARP) begin
          rec.arp_hw_type    = cap_arp[63:48];
          rec.arp_proto_type = cap_arp[47:32];
          rec.arp_addr_lens  = cap_arp[31:16];
          rec.arp_opcode     = cap_arp[15:0];
        end
      end
      clear_capture();
      emit = 1'b1;
    end
  endtask

  function automatic string format_header(header_rec_t r);
    return $sformatf("pass=%0d kind=%0d dmac=%h smac=%h sip=%h dip=%h sp=%h dp=%h arp=%h/%h/%h/%h",
                     r.pass, r.kind, r.dest_mac, r.source_mac, r.source_ip,
                     r.dest_ip, r.source_port, r.dest_port, r.arp_hw_type,
                     r.arp_proto_type, r.arp_addr_lens, r.arp_opcode);
  endfunction

  task automatic note_mismatch(string what, header_rec_t want, header_rec_t got);
    header_mismatches++;
    if (header_mismatches <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", format_header(want));
      $display("  actual   %s", format_header(got));
    end
  endtask

  // model update, result check and stall counting all at the sampling edge;
  // the model goes first so a result can never overtake its own expectation
  always @(posedge clk) begin : track_and_check
    header_rec_t want;
    header_rec_t got;
    bit          emit;
    bit          in_hs;
    bit          out_hs;
    in_hs  = frame_in.valid === 1'b1 && frame_in.ready === 1'b1;
    out_hs = result_out.valid === 1'b1 && result_out.ready === 1'b1;
    if (!rst_n) begin
      clear_capture();
      shadow_ip_en   = 1'b0;
      shadow_ip_addr = '0;
      shadow_mode    = MODE_NONE;
      shadow_proto   = '0;
      stall_cycles   = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_IP_FILTER_ENABLE:  shadow_ip_en   = cfg_wr_data[0];
          REG_IP_FILTER_ADDRESS: shadow_ip_addr = cfg_wr_data;
          REG_FILTER_MODE:       shadow_mode    = cfg_wr_data[1:0];
          REG_FILTER_PROTOCOL:   shadow_proto   = cfg_wr_data[7:0];
          default: ;
        endcase
      end

      if (in_hs) begin
        parse_header_byte(frame_in.frame_byte, frame_in.last_byte, emit, want);
        if (emit) begin
          // typed-in rows replace the model's answer
          if (item_pinned) want = item_pin;
          expected_headers.push_back(want);
        end
      end

      if (out_hs) begin
        got.pass           = result_out.pass;
        got.kind           = result_out.kind;
        got.dest_mac       = result_out.dest_mac;
        got.source_mac     = result_out.source_mac;
        got.source_ip      = result_out.source_ip;
        got.dest_ip        = result_out.dest_ip;
        got.source_port    = result_out.source_port;
        got.dest_port      = result_out.dest_port;
        got.arp_hw_type    = result_out.arp_hardware_type;
        got.arp_proto_type = result_out.arp_protocol_type;
        got.arp_addr_lens  = result_out.arp_address_lengths;
        got.arp_opcode     = result_out.arp_opcode;
        if (expected_headers.size() == 0) begin
          note_mismatch("header result with nothing pending", '0, got);
        end else begin
          want = expected_headers.pop_front();
          if (got !== want) note_mismatch("header result mismatch", want, got);
        end
        results_checked++;
        if (got.pass === 1'b1) results_shown++;
        if (!$isunknown(got.kind)) kinds_seen[got.kind]++;
      end

      if (in_hs || out_hs || cfg_wr_en) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // watchdog on cycles where nothing moves
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("ethernet_ipv4_arp_header_filter_unit_test failed");
    $finish;
  end

  // result side: runs of ready broken by random stalls, sometimes long runs
  initial begin : result_sink
    int run;
    int hold;
    result_out.ready <= 1'b0;
    repeat (8) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      result_out.ready <= 1'b1;
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        result_out.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // stop sending and wait until every pending result has been taken,
  // then let the result register settle
  task automatic drain_results();
    frame_in.valid <= 1'b0;
    @(posedge clk);
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write all four filter registers back to back; unused upper data bits
  // carry junk, which the block has to ignore
  task automatic apply_config(logic en, logic [31:0] addr, logic [1:0] mode,
                              logic [7:0] proto);
    cfg_data_t junk;
    cfg_wr_en <= 1'b1;
    junk = $urandom;
    junk[0] = en;
    cfg_index   <= REG_IP_FILTER_ENABLE;
    cfg_wr_data <= junk;
    @(posedge clk);
    cfg_index   <= REG_IP_FILTER_ADDRESS;
    cfg_wr_data <= addr;
    @(posedge clk);
    junk = $urandom;
    junk[1:0] = mode;
    cfg_index   <= REG_FILTER_MODE;
    cfg_wr_data <= junk;
    @(posedge clk);
    junk = $urandom;
    junk[7:0] = proto;
    cfg_index   <= REG_FILTER_PROTOCOL;
    cfg_wr_data <= junk;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_en    = en;
    cur_addr  = addr;
    cur_mode  = mode;
    cur_proto = proto;
    config_changes++;
  endtask

  // build one frame from a row and push it through the input channel
  task automatic run_row(frame_row_t row);
    logic [7:0]  fb [0:MAX_FRAME-1];
    header_rec_t pin;
    int          len;
    int          base;
    int          gap;
    bit          burst;
    if (row.flt_en != cur_en || row.flt_addr != cur_addr ||
        row.flt_mode != cur_mode || row.flt_proto != cur_proto) begin
      drain_results();
      apply_config(row.flt_en, row.flt_addr, row.flt_mode, row.flt_proto);
    end

    len = int'(row.length);
    for (int i = 0; i < len; i++) fb[i] = row.random_fill ? 8'($urandom) : row.fill;
    if (len > 12) fb[12] = row.ethertype[15:8];
    if (len > 13) fb[13] = row.ethertype[7:0];
    if (row.ethertype == ETHERTYPE_IPV4 && len > int'(POS_IP_PROTO))
      fb[POS_IP_PROTO] = row.ip_proto;

    // plant the filter address where the parser picks up an address
    base = -1;
    if (row.ethertype == ETHERTYPE_IPV4) begin
      if (row.addr_slot == SLOT_SOURCE) base = int'(POS_IP_SRC);
      else if (row.addr_slot == SLOT_DEST) base = int'(POS_IP_DST);
    end else if (row.ethertype == ETHERTYPE_ARP) begin
      if (row.addr_slot == SLOT_SOURCE) base = int'(POS_ARP_SENDER);
      else if (row.addr_slot == SLOT_DEST) base = int'(POS_ARP_TARGET);
    end
    if (base >= 0)
      for (int k = 0; k < 4; k++)
        if (base + k < len) fb[base + k] = row.flt_addr[31 - 8 * k -: 8];

    // typed-in result: truncated frames carry only their kind, mac-only rows with a
    // fixed fill carry that fill in both addresses
    pin = '0;
    pin.kind = row.pin_kind;
    if (row.pin_kind == KIND_MAC) begin
      pin.pass       = row.pin_pass;
      pin.dest_mac   = {6{row.fill}};
      pin.source_mac = {6{row.fill}};
    end

    burst = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      frame_in.valid      <= 1'b1;
      frame_in.frame_byte <= fb[i];
      frame_in.last_byte  <= (i == len - 1);
      item_pinned         <= row.pinned;
      item_pin            <= pin;
      do @(posedge clk); while (frame_in.ready !== 1'b1);
      bytes_sent++;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
        frame_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    frames_sent++;
  endtask

  // random frame under the current filter setting: mostly well-formed ipv4
  // and arp, the rest short, long, near-miss ethertypes and noise
  function automatic frame_row_t random_row();
    frame_row_t row;
    int cat;
    int pick;
    int min_len;
    row = '0;
    row.random_fill = ($urandom_range(0, 9) != 0);
    row.fill        = $urandom_range(0, 1) ? 8'hff : 8'h00;
    row.addr_slot   = 2'($urandom_range(0, 2));
    row.ip_proto    = 8'($urandom);
    row.flt_en      = cur_en;
    row.flt_addr    = cur_addr;
    row.flt_mode    = cur_mode;
    row.flt_proto   = cur_proto;
    cat  = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (cat < 40) begin
      row.ethertype = ETHERTYPE_IPV4;
      case ($urandom_range(0, 4))
        0: row.ip_proto = PROTO_TCP;
        1: row.ip_proto = PROTO_UDP;
        2: row.ip_proto = PROTO_ICMP;
        3: row.ip_proto = cur_proto;
        default: ;
      endcase
      min_len = (row.ip_proto == PROTO_TCP || row.ip_proto == PROTO_UDP) ?
                int'(LEN_IP_PORTS) : int'(LEN_IP_ADDR);
      if (pick == 0) row.length = 7'($urandom_range(int'(LEN_ETH), min_len - 1));
      else if (pick == 1) row.length = 7'($urandom_range(64, MAX_FRAME));
      else row.length = 7'($urandom_range(min_len, min_len + 12));
    end else if (cat < 65) begin
      row.ethertype = ETHERTYPE_ARP;
      if (pick == 0) row.length = 7'($urandom_range(int'(LEN_ETH), int'(LEN_ARP) - 1));
      else if (pick == 1) row.length = 7'($urandom_range(64, MAX_FRAME));
      else row.length = 7'($urandom_range(int'(LEN_ARP), int'(LEN_ARP) + 10));
    end else if (cat < 80) begin
      row.ethertype = 16'($urandom);
      row.length = (pick == 0) ? 7'($urandom_range(31, MAX_FRAME)) : 7'($urandom_range(14, 30));
    end else if (cat < 90) begin
      // one bit away from ipv4 or arp
      row.ethertype = ($urandom_range(0, 1) ? ETHERTYPE_IPV4 : ETHERTYPE_ARP) ^
                      (16'h1 << $urandom_range(0, 15));
      row.length = 7'($urandom_range(14, 44));
    end else begin
      row.ethertype = 16'($urandom);
      row.length = 7'($urandom_range(1, 16));
    end
    return row;
  endfunction

  // directed frames; rows with pinned set carry their result typed in
  initial begin
    //          ethertype       proto       len     fill   rnd   slot
    //          en    addr           mode             proto  pin   kind            pass
    plan[0]  = '{16'h0000,      8'h00,      7'd14, 8'h00, 1'b0, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b1, KIND_MAC,       1'b1};
    plan[1]  = '{16'hffff,      8'h00,      7'd14, 8'hff, 1'b0, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b1, KIND_MAC,       1'b1};
    plan[2]  = '{16'h0000,      8'h00,      7'd1,  8'hff, 1'b0, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b1, KIND_TRUNCATED, 1'b0};
    plan[3]  = '{16'h0000,      8'h00,      7'd13, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b1, KIND_TRUNCATED, 1'b0};
    plan[4]  = '{ETHERTYPE_IPV4, PROTO_TCP, 7'd23, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b1, KIND_TRUNCATED, 1'b0};
    plan[5]  = '{ETHERTYPE_IPV4, PROTO_TCP, 7'd37, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b1, KIND_TRUNCATED, 1'b0};
    plan[6]  = '{ETHERTYPE_IPV4, PROTO_TCP, 7'd38, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[7]  = '{ETHERTYPE_IPV4, PROTO_UDP, 7'd60, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[8]  = '{ETHERTYPE_IPV4, PROTO_ICMP, 7'd33, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b1, KIND_TRUNCATED, 1'b0};
    plan[9]  = '{ETHERTYPE_IPV4, PROTO_ICMP, 7'd34, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[10] = '{ETHERTYPE_IPV4, 8'hff,     7'd64, 8'hff, 1'b0, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[11] = '{ETHERTYPE_ARP, 8'h00,      7'd41, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b1, KIND_TRUNCATED, 1'b0};
    plan[12] = '{ETHERTYPE_ARP, 8'h00,      7'd42, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    // bytes past the saturation point must not disturb anything
    plan[13] = '{16'h1234,      8'h00,      7'd80, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    // address filter: hit on source, miss, hit on arp target, mac-only exempt
    plan[14] = '{ETHERTYPE_IPV4, PROTO_TCP, 7'd40, 8'h00, 1'b1, SLOT_SOURCE,
                 1'b1, 32'hffffffff, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[15] = '{ETHERTYPE_IPV4, PROTO_UDP, 7'd40, 8'h00, 1'b1, SLOT_NONE,
                 1'b1, 32'hffffffff, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[16] = '{ETHERTYPE_ARP, 8'h00,      7'd50, 8'h00, 1'b1, SLOT_DEST,
                 1'b1, 32'h00000000, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[17] = '{16'h88cc,      8'h00,      7'd20, 8'h00, 1'b1, SLOT_NONE,
                 1'b1, 32'h00000000, MODE_NONE,       8'h00, 1'b0, KIND_MAC,       1'b0};
    // mode filters, each with a frame that fails and one that passes
    plan[18] = '{ETHERTYPE_ARP, 8'h00,      7'd42, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_IPV4,       8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[19] = '{ETHERTYPE_IPV4, 8'h2f,     7'd34, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_IPV4,       8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[20] = '{ETHERTYPE_IPV4, PROTO_TCP, 7'd38, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_ARP,        8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[21] = '{ETHERTYPE_ARP, 8'h00,      7'd42, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_ARP,        8'h00, 1'b0, KIND_MAC,       1'b0};
    plan[22] = '{ETHERTYPE_IPV4, PROTO_TCP, 7'd44, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_IPV4_PROTO, PROTO_TCP, 1'b0, KIND_MAC,   1'b0};
    plan[23] = '{ETHERTYPE_IPV4, PROTO_UDP, 7'd44, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_IPV4_PROTO, 8'hff, 1'b0, KIND_MAC,       1'b0};
    plan[24] = '{ETHERTYPE_IPV4, 8'hff,     7'd40, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_IPV4_PROTO, 8'hff, 1'b0, KIND_MAC,       1'b0};
    // back to reset values, short tcp frame
    plan[25] = '{ETHERTYPE_IPV4, PROTO_TCP, 7'd30, 8'h00, 1'b1, SLOT_NONE,
                 1'b0, 32'h00000000, MODE_NONE,       8'h00, 1'b1, KIND_TRUNCATED, 1'b0};
  end

  // main sequence: reset, directed frames, random frames, drain, verdict
  initial begin : frame_source
    frame_row_t row;
    int random_frames;
    int start_bytes;
    logic [31:0] addr;
    logic [7:0]  proto;
    random_frames = 0;
    foreach (kinds_seen[i]) kinds_seen[i] = 0;
    frame_in.valid      <= 1'b0;
    frame_in.frame_byte <= 8'h00;
    frame_in.last_byte  <= 1'b0;
    item_pinned         <= 1'b0;
    item_pin            <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= REG_IP_FILTER_ENABLE;
    cfg_wr_data         <= '0;
    cur_en    = 1'b0;
    cur_addr  = '0;
    cur_mode  = MODE_NONE;
    cur_proto = '0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_PLAN; i++) run_row(plan[i]);

    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES || random_frames < RANDOM_FRAMES) begin
      // new filter setting every few frames, extremes picked often
      if (random_frames % 3 == 0) begin
        case ($urandom_range(0, 3))
          0: addr = 32'h00000000;
          1: addr = 32'hffffffff;
          2: addr = 32'hc0a80001;
          default: addr = $urandom;
        endcase
        case ($urandom_range(0, 5))
          0: proto = 8'h00;
          1: proto = 8'hff;
          2: proto = PROTO_TCP;
          3: proto = PROTO_UDP;
          4: proto = PROTO_ICMP;
          default: proto = 8'($urandom);
        endcase
        drain_results();
        apply_config(1'($urandom_range(0, 1)), addr, 2'($urandom_range(0, 3)), proto);
      end
      row = random_row();
      run_row(row);
      random_frames++;
      // occasionally hold off until the block has emptied
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (5) @(posedge clk);

    $display("covered %0d frames, %0d bytes, %0d filter settings; %0d results, %0d shown",
             frames_sent, bytes_sent, config_changes, results_checked, results_shown);
    $display("kinds: mac %0d tcp %0d udp %0d icmp %0d ipv4 %0d arp %0d truncated %0d",
             kinds_seen[KIND_MAC], kinds_seen[KIND_TCP], kinds_seen[KIND_UDP],
             kinds_seen[KIND_ICMP], kinds_seen[KIND_IPV4], kinds_seen[KIND_ARP],
             kinds_seen[KIND_TRUNCATED]);
    if (header_mismatches == 0 && expected_headers.size() == 0)
      $display("ethernet_ipv4_arp_header_filter_unit_test passed");
    else
      $display("ethernet_ipv4_arp_header_filter_unit_test failed");
    $finish;
  end

endmodule
